FILE: hw/rtl/rfim_pkg.sv
`default_nettype none

package rfim_pkg;

  // byte and field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned IdleW    = 16;
  localparam int unsigned TdataW   = 24;
  localparam int unsigned TuserW   = 2;

  // longest frame kept before it is dropped
  localparam int unsigned MaxFrameLen = 128;

  // frame bytes 2..6 are kept
  localparam int unsigned HeadBase  = 2;
  localparam int unsigned HeadDepth = 5;

  // header and tail marks
  localparam logic [ByteW-1:0] SyncA = 8'h53;
  localparam logic [ByteW-1:0] SyncB = 8'h59;
  localparam logic [ByteW-1:0] EndA  = 8'h54;
  localparam logic [ByteW-1:0] EndB  = 8'h43;

  // report codes
  localparam logic [ByteW-1:0] FallCtrl  = 8'h83;
  localparam logic [ByteW-1:0] MoveCtrl  = 8'h80;
  localparam logic [ByteW-1:0] MoveCmd   = 8'h03;
  localparam logic [ByteW-1:0] CodeZero  = 8'h00;
  localparam logic [ByteW-1:0] CodeOne   = 8'h01;

  localparam logic [ByteW-1:0] ReportLen   = 8'd10;
  localparam logic [ByteW-1:0] MinFrameLen = 8'd4;
  localparam logic [ByteW-1:0] IdleLimit   = 8'd10;

  // tuser bit positions
  localparam int unsigned UserFallBit = 0;
  localparam int unsigned UserMoveBit = 1;

  // tdata layout
  localparam int unsigned DataLevelLsb   = 0;
  localparam int unsigned DataTimeoutBit = 8;
  localparam int unsigned DataLenLsb     = 9;

endpackage

`default_nettype wire

FILE: hw/rtl/radar_frame_fall_idle_monitor.sv
`default_nettype none

// channel   | direction | tdata (lsb first)                            | tuser (lsb first)
// s_axis    | in        | rx_byte[7:0]                                 | -
// m_axis    | out       | movement_level[7:0], idle_timeout,           | fall_event,
//           |           | frame_length[7:0], 7 zero bits               | movement_valid
// cfg       | in        | cfg_wdata_i = idle_threshold[15:0], no read  | -
//
// one byte per cycle sustained while results are taken; a frame's result is registered in the
// output register as its last byte leaves the input register
// the frame parser and idle counter are updated once per byte as it leaves the input register
// reset clears parser state, idle count, threshold and both valid flags; kept frame bytes
// are not cleared
// a stalled result holds the output register; one more byte is taken into the input
// register, then s_axis_tready drops until the result is taken

module radar_frame_fall_idle_monitor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write
  input  wire logic                        cfg_we_i,
  input  wire logic [rfim_pkg::IdleW-1:0]  cfg_wdata_i,   // idle_threshold
  // byte stream in
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [rfim_pkg::ByteW-1:0]  s_axis_tdata,  // rx_byte[7:0]
  // frame results out
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [rfim_pkg::TdataW-1:0]      m_axis_tdata,  // level[7:0], timeout, length[7:0]
  output logic [rfim_pkg::TuserW-1:0]      m_axis_tuser   // fall_event, movement_valid
);
  import rfim_pkg::*;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;

  // parser and idle state
  logic             in_frame_q, in_frame_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] prev_q;
  logic [ByteW-1:0] head_q [HeadDepth];
  logic [IdleW-1:0] idle_q, idle_d;
  logic [IdleW-1:0] thresh_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [TdataW-1:0] out_data_q, out_data_d;
  logic [TuserW-1:0] out_user_q, out_user_d;

  logic             adv;
  logic             live;        // still in a frame after the overlong check
  logic [ByteW-1:0] count_cur;
  logic [ByteW-1:0] count_inc;
  logic             tail_hit;
  logic             done;
  logic             fall;
  logic             move;
  logic [ByteW-1:0] level;
  logic             timeout;
  logic [IdleW-1:0] idle_inc;

  // byte leaves the input register when the result slot is free or draining
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_comb begin
    in_valid_d = s_axis_tvalid && s_axis_tready ? 1'b1 : (adv ? 1'b0 : in_valid_q);

    // a frame that reached the limit is dropped before this byte is looked at
    live      = in_frame_q && (count_q < ByteW'(MaxFrameLen));
    count_cur = live ? count_q : '0;
    count_inc = count_cur + ByteW'(1);
    tail_hit  = (prev_q == EndA) && (in_byte_q == EndB);
    done      = live && tail_hit;

    // kept bytes come from earlier cycles whenever the length is 10 or more
    fall = (count_inc >= ReportLen) && (head_q[0] == FallCtrl) &&
           (head_q[1] == CodeOne) && (head_q[4] == CodeOne);
    move = (count_inc == ReportLen) && (head_q[0] == MoveCtrl) &&
           (head_q[1] == MoveCmd) && (head_q[2] == CodeZero) &&
           (head_q[3] == CodeOne);
    level = move ? head_q[4] : '0;

    idle_inc = (&idle_q) ? idle_q : idle_q + IdleW'(1);
    timeout  = 1'b0;
    idle_d   = idle_q;
    if (done && move) begin
      if (level < IdleLimit) begin
        if ((thresh_q != '0) && (idle_inc >= thresh_q)) begin
          timeout = 1'b1;
          idle_d  = '0;
        end else begin
          idle_d = idle_inc;
        end
      end else begin
        // active movement restarts the idle count
        idle_d = '0;
      end
    end

    if (!live) begin
      if ((prev_q == SyncA) && (in_byte_q == SyncB)) begin
        in_frame_d = 1'b1;
        count_d    = ByteW'(HeadBase);
      end else begin
        in_frame_d = 1'b0;
        count_d    = '0;
      end
    end else if (tail_hit) begin
      in_frame_d = 1'b0;
      count_d    = '0;
    end else begin
      in_frame_d = 1'b1;
      count_d    = count_inc;
    end

    out_data_d = '0;
    out_data_d[DataLevelLsb +: ByteW] = level;
    out_data_d[DataTimeoutBit]        = timeout;
    out_data_d[DataLenLsb +: ByteW]   = count_inc;
    out_user_d = '0;
    out_user_d[UserFallBit] = fall;
    out_user_d[UserMoveBit] = move;

    if (adv && done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_frame_q  <= 1'b0;
      count_q     <= '0;
      prev_q      <= '0;
      idle_q      <= '0;
      thresh_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (adv) begin
        in_frame_q <= in_frame_d;
        count_q    <= count_d;
        prev_q     <= in_byte_q;
        idle_q     <= idle_d;
      end
    end
  end

  // payload: input byte, kept frame bytes, result
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (adv && live) begin
      for (int i = 0; i < HeadDepth; i++) begin
        if (count_cur == ByteW'(HeadBase + i)) begin
          head_q[i] <= in_byte_q;
        end
      end
    end
    if (adv && done) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rfim_checker.sv
`default_nettype none

module rfim_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [rfim_pkg::TdataW-1:0] m_axis_tdata,
  input wire logic [rfim_pkg::TuserW-1:0] m_axis_tuser
);
  import rfim_pkg::*;

  logic [ByteW-1:0] len;
  logic [ByteW-1:0] lvl;
  logic             tmo;
  logic             fall;
  logic             move;

  assign len  = m_axis_tdata[DataLenLsb +: ByteW];
  assign lvl  = m_axis_tdata[DataLevelLsb +: ByteW];
  assign tmo  = m_axis_tdata[DataTimeoutBit];
  assign fall = m_axis_tuser[UserFallBit];
  assign move = m_axis_tuser[UserMoveBit];

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("stalled result changed");

  // frame length within header-plus-tail and the drop limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (len >= MinFrameLen) && (len <= ByteW'(MaxFrameLen)))
    else $error("frame length out of range");

  // a frame cannot be both kinds of report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(fall && move))
    else $error("fall and movement both set");

  // movement report has the fixed length, level zero otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (move && (len == ReportLen)) || (!move && (lvl == '0)))
    else $error("movement fields inconsistent");

  // timeout only on an idle movement report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && tmo |-> move && (lvl < IdleLimit))
    else $error("timeout without idle movement");

endmodule

bind radar_frame_fall_idle_monitor rfim_checker u_rfim_checker (.*);

`default_nettype wire
